FILE: design/rfid_reply_frame_parser_macros.svh
// Assertion macros shared by the reply frame parser modules.
`ifndef RFID_REPLY_FRAME_PARSER_MACROS_SVH
`define RFID_REPLY_FRAME_PARSER_MACROS_SVH

`ifndef SYNTH
`define RFP_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define RFP_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`else
`define RFP_ASSERT(lbl, clk, rst_n, prop, msg)
`define RFP_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

FILE: design/rfp_pkg.sv
// Types and constants of the reply frame parser.
`timescale 1ns / 1ps
`default_nettype none

package rfp_pkg;

  localparam logic [7:0] CMD_READ_SERIAL = 8'h11;
  localparam logic [7:0] STATUS_OK       = 8'h00;
  localparam logic [7:0] TYPE_ID_OK      = 8'h00;

  localparam logic [7:0] MIN_LEN_PLAIN   = 8'd5;
  localparam logic [7:0] MIN_LEN_GENERIC = 8'd6;

  localparam logic [7:0] OFS_LENGTH     = 8'd0;
  localparam logic [7:0] OFS_ADDR       = 8'd1;
  localparam logic [7:0] OFS_CMD        = 8'd2;
  localparam logic [7:0] OFS_STATUS     = 8'd3;
  localparam logic [7:0] OFS_FIRST_DATA = 8'd4;

  typedef enum logic {
    KIND_PAYLOAD = 1'b0,
    KIND_END     = 1'b1
  } kind_e;

  typedef enum logic [2:0] {
    ERR_NONE   = 3'd0,
    ERR_CMD    = 3'd1,
    ERR_STATUS = 3'd2,
    ERR_TYPE   = 3'd3,
    ERR_SHORT  = 3'd4
  } err_e;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] payload_byte;
    logic [7:0] reader_address;
    logic [7:0] command_id;
    logic [7:0] status_code;
    logic       checksum_ok;
    err_e       error_code;
    logic [7:0] frame_length;
  } result_t;

endpackage

`default_nettype wire

FILE: design/rfp_core.sv
// Frame state, running checksum and result formation for one item per cycle while accept_i is high.
`timescale 1ns / 1ps
`default_nettype none

`include "rfid_reply_frame_parser_macros.svh"

module rfp_core (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            cfg_we_i,
  input  wire logic            cfg_data_i,
  input  wire logic            accept_i,
  input  wire logic [7:0]      rx_byte_i,
  output logic                 res_valid_o,
  output rfp_pkg::result_t     res_o
);

  logic       generic_q;
  logic [7:0] offset_q, offset_d;
  logic [7:0] total_q, total_d;
  logic [7:0] addr_q, addr_d;
  logic [7:0] cmd_q, cmd_d;
  logic [7:0] status_q, status_d;
  logic [7:0] xor_q, xor_d;
  logic       type_bad_q, type_bad_d;
  logic [7:0] min_len;
  logic [7:0] last_offset;

  assign min_len     = generic_q ? rfp_pkg::MIN_LEN_GENERIC : rfp_pkg::MIN_LEN_PLAIN;
  assign last_offset = total_q - 8'd1;

  always_comb begin
    offset_d    = offset_q;
    total_d     = total_q;
    addr_d      = addr_q;
    cmd_d       = cmd_q;
    status_d    = status_q;
    xor_d       = xor_q;
    type_bad_d  = type_bad_q;
    res_valid_o = 1'b0;
    res_o       = '0;
    if (accept_i) begin
      priority if (offset_q == rfp_pkg::OFS_LENGTH) begin
        total_d    = rx_byte_i;
        xor_d      = rx_byte_i;
        type_bad_d = 1'b0;
        addr_d     = '0;
        cmd_d      = '0;
        status_d   = '0;
        if (rx_byte_i < min_len) begin
          res_valid_o        = 1'b1;
          res_o.kind         = rfp_pkg::KIND_END;
          res_o.error_code   = rfp_pkg::ERR_SHORT;
          res_o.frame_length = rx_byte_i;
        end else begin
          offset_d = rfp_pkg::OFS_ADDR;
        end
      end else if (offset_q < rfp_pkg::OFS_FIRST_DATA) begin
        if (offset_q == rfp_pkg::OFS_ADDR) begin
          addr_d = rx_byte_i;
        end
        if (offset_q == rfp_pkg::OFS_CMD) begin
          cmd_d = rx_byte_i;
        end
        if (offset_q == rfp_pkg::OFS_STATUS) begin
          status_d = rx_byte_i;
        end
        xor_d    = xor_q ^ rx_byte_i;
        offset_d = offset_q + 8'd1;
      end else if (offset_q == last_offset) begin
        res_valid_o          = 1'b1;
        res_o.kind           = rfp_pkg::KIND_END;
        res_o.reader_address = addr_q;
        res_o.command_id     = cmd_q;
        res_o.status_code    = status_q;
        res_o.checksum_ok    = (rx_byte_i == xor_q);
        res_o.frame_length   = total_q;
        priority if (cmd_q != rfp_pkg::CMD_READ_SERIAL) begin
          res_o.error_code = rfp_pkg::ERR_CMD;
        end else if (status_q != rfp_pkg::STATUS_OK) begin
          res_o.error_code = rfp_pkg::ERR_STATUS;
        end else if (type_bad_q) begin
          res_o.error_code = rfp_pkg::ERR_TYPE;
        end else begin
          res_o.error_code = rfp_pkg::ERR_NONE;
        end
        offset_d = rfp_pkg::OFS_LENGTH;
        xor_d    = '0;
      end else begin
        xor_d    = xor_q ^ rx_byte_i;
        offset_d = offset_q + 8'd1;
        if (offset_q == rfp_pkg::OFS_FIRST_DATA && generic_q) begin
          type_bad_d = (rx_byte_i != rfp_pkg::TYPE_ID_OK);
        end else begin
          res_valid_o        = 1'b1;
          res_o.kind         = rfp_pkg::KIND_PAYLOAD;
          res_o.payload_byte = rx_byte_i;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      generic_q  <= 1'b0;
      offset_q   <= '0;
      total_q    <= '0;
      addr_q     <= '0;
      cmd_q      <= '0;
      status_q   <= '0;
      xor_q      <= '0;
      type_bad_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        generic_q <= cfg_data_i;
      end
      offset_q   <= offset_d;
      total_q    <= total_d;
      addr_q     <= addr_d;
      cmd_q      <= cmd_d;
      status_q   <= status_d;
      xor_q      <= xor_d;
      type_bad_q <= type_bad_d;
    end
  end

  `RFP_ASSERT_IMP(a_offset_below_total, clk_i, rst_ni,
                  offset_q != rfp_pkg::OFS_LENGTH, offset_q < total_q,
                  "Byte offset ran past the frame length.")
  `RFP_ASSERT_IMP(a_total_long_enough, clk_i, rst_ni,
                  offset_q != rfp_pkg::OFS_LENGTH, total_q >= rfp_pkg::MIN_LEN_PLAIN,
                  "A frame shorter than the minimum was opened.")
  `RFP_ASSERT_IMP(a_end_restarts, clk_i, rst_ni,
                  res_valid_o && res_o.kind == rfp_pkg::KIND_END,
                  ##1 offset_q == rfp_pkg::OFS_LENGTH,
                  "The item after an end of frame is not taken as a length byte.")

endmodule

`default_nettype wire

FILE: design/rfid_reply_frame_parser.sv
// Top level of the reply frame parser: frame core and two-entry result buffer.
`timescale 1ns / 1ps
`default_nettype none

`include "rfid_reply_frame_parser_macros.svh"

// Accepts one reply byte per cycle while the input is not stalled and delivers
// its result, if any, from a registered output. The frame core keeps the byte
// offset, the captured header and the running XOR. A two-entry result buffer
// (output register plus skid entry) separates the sides: input stall rises
// only when both entries are full, so a stalled output costs at most one more
// result before the input stalls. The user must write the generic format bit
// through the configuration port while idle; the block does not enforce this.
module rfid_reply_frame_parser (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       cfg_we_i,
  input  wire logic       cfg_data_i,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire logic [7:0] rx_byte_i,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output logic            kind_o,
  output logic [7:0]      payload_byte_o,
  output logic [7:0]      reader_address_o,
  output logic [7:0]      command_id_o,
  output logic [7:0]      status_code_o,
  output logic            checksum_ok_o,
  output logic [2:0]      error_code_o,
  output logic [7:0]      frame_length_o
);

  logic             in_fire;
  logic             out_fire;
  logic             res_valid;
  rfp_pkg::result_t res;
  logic             out_valid_q;
  logic             skid_valid_q;
  rfp_pkg::result_t out_q;
  rfp_pkg::result_t skid_q;

  assign in_stall_o = skid_valid_q;
  assign in_fire    = in_valid_i && !skid_valid_q;
  assign out_fire   = out_valid_q && !out_stall_i;

  rfp_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_data_i  (cfg_data_i),
    .accept_i    (in_fire),
    .rx_byte_i   (rx_byte_i),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      priority if (skid_valid_q) begin
        if (out_fire) begin
          skid_valid_q <= 1'b0;
        end
      end else if (res_valid) begin
        if (out_valid_q && !out_fire) begin
          skid_valid_q <= 1'b1;
        end else begin
          out_valid_q <= 1'b1;
        end
      end else begin
        if (out_fire) begin
          out_valid_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    priority if (skid_valid_q) begin
      if (out_fire) begin
        out_q <= skid_q;
      end
    end else begin
      if (res_valid) begin
        if (out_valid_q && !out_fire) begin
          skid_q <= res;
        end else begin
          out_q <= res;
        end
      end
    end
  end

  assign out_valid_o      = out_valid_q;
  assign kind_o           = out_q.kind;
  assign payload_byte_o   = out_q.payload_byte;
  assign reader_address_o = out_q.reader_address;
  assign command_id_o     = out_q.command_id;
  assign status_code_o    = out_q.status_code;
  assign checksum_ok_o    = out_q.checksum_ok;
  assign error_code_o     = out_q.error_code;
  assign frame_length_o   = out_q.frame_length;

  `RFP_ASSERT_IMP(a_skid_needs_out, clk_i, rst_ni,
                  skid_valid_q, out_valid_q,
                  "The skid entry is full while the output register is empty.")
  `RFP_ASSERT_IMP(a_payload_clean, clk_i, rst_ni,
                  out_valid_o && kind_o == rfp_pkg::KIND_PAYLOAD,
                  error_code_o == rfp_pkg::ERR_NONE && frame_length_o == 8'd0
                  && checksum_ok_o == 1'b0,
                  "A payload result carries end of frame fields.")
  `RFP_ASSERT_IMP(a_short_clean, clk_i, rst_ni,
                  out_valid_o && kind_o == rfp_pkg::KIND_END
                  && error_code_o == rfp_pkg::ERR_SHORT,
                  reader_address_o == 8'd0 && checksum_ok_o == 1'b0
                  && frame_length_o < rfp_pkg::MIN_LEN_GENERIC,
                  "A too short frame result carries header fields.")

endmodule

`default_nettype wire

FILE: tb/rfid_reply_frame_parser_test.sv
// Self-checking testbench of the reply frame parser with random idling on both sides.
`timescale 1ns / 1ps

module rfid_reply_frame_parser_test;

  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int BYTES_PER_PHASE = 210;
  localparam int KEEP_ALL = 256;
  localparam int NUM_PHASES = 6;
  localparam logic [NUM_PHASES-1:0] PHASE_MODES = 6'b010110;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we = 1'b0;
  logic cfg_data = 1'b0;
  logic in_valid = 1'b0;
  logic [7:0] rx_byte = 8'h00;
  logic out_stall = 1'b0;

  logic in_stall;
  logic out_valid;
  logic kind;
  logic [7:0] payload_byte;
  logic [7:0] reader_address;
  logic [7:0] command_id;
  logic [7:0] status_code;
  logic checksum_ok;
  logic [2:0] error_code;
  logic [7:0] frame_length;

  logic [7:0] reply_bytes[$];
  logic [7:0] split_tail[$];
  rfp_pkg::result_t reply_results[$];

  bit gen_mode = 1'b0;
  logic [7:0] byte_ofs = '0;
  logic [7:0] frame_total = '0;
  logic [7:0] addr_hold = '0;
  logic [7:0] cmd_hold = '0;
  logic [7:0] status_hold = '0;
  logic [7:0] xor_acc = '0;
  bit type_bad = 1'b0;

  int send_gap = 0;
  int stall_left = 0;
  bit send_burst = 1'b0;
  bit stall_burst = 1'b0;
  int failures = 0;
  int cycle_count = 0;
  rfp_pkg::result_t got;
  rfp_pkg::result_t want;

  rfid_reply_frame_parser u_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we),
    .cfg_data_i       (cfg_data),
    .in_valid_i       (in_valid),
    .in_stall_o       (in_stall),
    .rx_byte_i        (rx_byte),
    .out_valid_o      (out_valid),
    .out_stall_i      (out_stall),
    .kind_o           (kind),
    .payload_byte_o   (payload_byte),
    .reader_address_o (reader_address),
    .command_id_o     (command_id),
    .status_code_o    (status_code),
    .checksum_ok_o    (checksum_ok),
    .error_code_o     (error_code),
    .frame_length_o   (frame_length)
  );

  function automatic void parse_reply_byte(input logic [7:0] b);
    rfp_pkg::result_t r;
    r = '0;
    case (byte_ofs)
      rfp_pkg::OFS_LENGTH: begin
        frame_total = b;
        xor_acc = b;
        type_bad = 1'b0;
        addr_hold = '0;
        cmd_hold = '0;
        status_hold = '0;
        if (b < (gen_mode ? rfp_pkg::MIN_LEN_GENERIC : rfp_pkg::MIN_LEN_PLAIN)) begin
          r.kind = rfp_pkg::KIND_END;
          r.frame_length = b;
          r.error_code = rfp_pkg::ERR_SHORT;
          reply_results.push_back(r);
        end else begin
          byte_ofs = rfp_pkg::OFS_ADDR;
        end
      end
      rfp_pkg::OFS_ADDR, rfp_pkg::OFS_CMD, rfp_pkg::OFS_STATUS: begin
        if (byte_ofs == rfp_pkg::OFS_ADDR) addr_hold = b;
        else if (byte_ofs == rfp_pkg::OFS_CMD) cmd_hold = b;
        else status_hold = b;
        xor_acc = xor_acc ^ b;
        byte_ofs = byte_ofs + 8'd1;
      end
      default: begin
        if (byte_ofs == 8'(frame_total - 8'd1)) begin
          r.kind = rfp_pkg::KIND_END;
          r.reader_address = addr_hold;
          r.command_id = cmd_hold;
          r.status_code = status_hold;
          r.checksum_ok = (b == xor_acc);
          if (cmd_hold != rfp_pkg::CMD_READ_SERIAL) r.error_code = rfp_pkg::ERR_CMD;
          else if (status_hold != rfp_pkg::STATUS_OK) r.error_code = rfp_pkg::ERR_STATUS;
          else if (type_bad) r.error_code = rfp_pkg::ERR_TYPE;
          else r.error_code = rfp_pkg::ERR_NONE;
          r.frame_length = frame_total;
          reply_results.push_back(r);
          byte_ofs = rfp_pkg::OFS_LENGTH;
          xor_acc = '0;
        end else begin
          xor_acc = xor_acc ^ b;
          byte_ofs = byte_ofs + 8'd1;
          if (byte_ofs == rfp_pkg::OFS_FIRST_DATA + 8'd1 && gen_mode) begin
            type_bad = (b != rfp_pkg::TYPE_ID_OK);
          end else begin
            r.kind = rfp_pkg::KIND_PAYLOAD;
            r.payload_byte = b;
            reply_results.push_back(r);
          end
        end
      end
    endcase
  endfunction

  // Bytes past the first keep ones are held back to start the next phase.
  function automatic void build_frame(input logic [7:0] len, input logic [7:0] addr,
                                      input logic [7:0] cmd, input logic [7:0] status,
                                      input logic [7:0] type_id, input bit good_sum,
                                      input int keep);
    logic [7:0] fb[$];
    logic [7:0] sum;
    fb.push_back(len);
    if (len >= (gen_mode ? rfp_pkg::MIN_LEN_GENERIC : rfp_pkg::MIN_LEN_PLAIN)) begin
      fb.push_back(addr);
      fb.push_back(cmd);
      fb.push_back(status);
      for (int i = int'(rfp_pkg::OFS_FIRST_DATA); i < int'(len) - 1; i++) begin
        if (i == int'(rfp_pkg::OFS_FIRST_DATA) && gen_mode) fb.push_back(type_id);
        else fb.push_back(8'($urandom_range(0, 255)));
      end
      sum = '0;
      foreach (fb[j]) sum = sum ^ fb[j];
      fb.push_back(good_sum ? sum : sum ^ 8'($urandom_range(1, 255)));
    end
    foreach (fb[j]) begin
      if (j < keep) reply_bytes.push_back(fb[j]);
      else split_tail.push_back(fb[j]);
    end
  endfunction

  function automatic logic [7:0] pick_byte(input logic [7:0] good);
    if ($urandom_range(0, 99) < 85) return good;
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic void random_frame();
    int sel;
    logic [7:0] len;
    logic [7:0] minlen;
    sel = $urandom_range(0, 99);
    minlen = gen_mode ? rfp_pkg::MIN_LEN_GENERIC : rfp_pkg::MIN_LEN_PLAIN;
    if (sel < 6) len = 8'($urandom_range(0, int'(minlen) - 1));
    else if (sel < 11) len = 8'($urandom_range(0, 255));
    else if (sel < 80) len = 8'($urandom_range(int'(minlen), 12));
    else if (sel < 97) len = 8'($urandom_range(13, 40));
    else len = 8'($urandom_range(41, 255));
    build_frame(len, 8'($urandom_range(0, 255)), pick_byte(rfp_pkg::CMD_READ_SERIAL),
                pick_byte(rfp_pkg::STATUS_OK), pick_byte(rfp_pkg::TYPE_ID_OK),
                $urandom_range(0, 99) < 90, KEEP_ALL);
  endfunction

  function automatic int pick_idle(inout bit burst);
    int sel;
    if ($urandom_range(0, 63) == 0) burst = !burst;
    sel = $urandom_range(0, 99);
    if (burst || sel < 60) return 0;
    if (sel < 92) return $urandom_range(1, 3);
    return $urandom_range(5, 30);
  endfunction

  function automatic string show(input rfp_pkg::result_t r);
    return $sformatf("kind=%0d payload=%h addr=%h cmd=%h status=%h ok=%0d err=%0d len=%h",
                     r.kind, r.payload_byte, r.reader_address, r.command_id,
                     r.status_code, r.checksum_ok, r.error_code, r.frame_length);
  endfunction

  task automatic wait_idle();
    do @(posedge clk_i);
    while (reply_bytes.size() != 0 || in_valid || reply_results.size() != 0);
    repeat (4) @(posedge clk_i);
  endtask

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
      rx_byte <= 8'h00;
      send_gap = 0;
    end else if (!in_valid || !in_stall) begin
      if (in_valid) parse_reply_byte(rx_byte);
      if (send_gap > 0 || reply_bytes.size() == 0) begin
        if (send_gap > 0) send_gap--;
        in_valid <= 1'b0;
      end else begin
        in_valid <= 1'b1;
        rx_byte <= reply_bytes.pop_front();
        send_gap = pick_idle(send_burst);
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid && !out_stall) begin
        got = '{rfp_pkg::kind_e'(kind), payload_byte, reader_address, command_id,
                status_code, checksum_ok, rfp_pkg::err_e'(error_code), frame_length};
        if (reply_results.size() == 0) begin
          failures++;
          if (failures <= 10) $display("Result with none expected: %s", show(got));
        end else begin
          want = reply_results.pop_front();
          if (got.kind !== want.kind || got.payload_byte !== want.payload_byte ||
              got.reader_address !== want.reader_address ||
              got.command_id !== want.command_id || got.status_code !== want.status_code ||
              got.checksum_ok !== want.checksum_ok || got.error_code !== want.error_code ||
              got.frame_length !== want.frame_length) begin
            failures++;
            if (failures <= 10) begin
              $display("Result mismatch: expected %s", show(want));
              $display("                 actual   %s", show(got));
            end
          end
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
        if ($urandom_range(0, 3) == 0) stall_left = pick_idle(stall_burst);
      end
    end
  end

  initial begin
    int base;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    for (int p = 0; p < NUM_PHASES; p++) begin
      @(posedge clk_i);
      cfg_we <= 1'b1;
      cfg_data <= PHASE_MODES[p];
      @(posedge clk_i);
      cfg_we <= 1'b0;
      gen_mode = PHASE_MODES[p];
      // The frame left open by the previous phase finishes under the new mode.
      while (split_tail.size() > 0) reply_bytes.push_back(split_tail.pop_front());
      if (p == 0) begin
        build_frame(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 1'b1, KEEP_ALL);
        build_frame(8'h04, 8'h00, 8'h00, 8'h00, 8'h00, 1'b1, KEEP_ALL);
        build_frame(8'h05, 8'h00, rfp_pkg::CMD_READ_SERIAL, rfp_pkg::STATUS_OK,
                    rfp_pkg::TYPE_ID_OK, 1'b1, KEEP_ALL);
        build_frame(8'h06, 8'hFF, 8'hFF, rfp_pkg::STATUS_OK, rfp_pkg::TYPE_ID_OK, 1'b0,
                    KEEP_ALL);
        build_frame(8'h06, 8'h5A, rfp_pkg::CMD_READ_SERIAL, 8'hFF, rfp_pkg::TYPE_ID_OK,
                    1'b1, KEEP_ALL);
        build_frame(8'h05, 8'hA5, 8'h00, 8'h01, rfp_pkg::TYPE_ID_OK, 1'b1, KEEP_ALL);
      end else if (p == 1) begin
        build_frame(8'h05, 8'h00, 8'h00, 8'h00, 8'h00, 1'b1, KEEP_ALL);
        build_frame(8'h06, 8'h3C, rfp_pkg::CMD_READ_SERIAL, rfp_pkg::STATUS_OK, 8'hFF,
                    1'b1, KEEP_ALL);
        build_frame(8'h07, 8'hC3, rfp_pkg::CMD_READ_SERIAL, rfp_pkg::STATUS_OK,
                    rfp_pkg::TYPE_ID_OK, 1'b1, KEEP_ALL);
        build_frame(8'h06, 8'h81, rfp_pkg::CMD_READ_SERIAL, 8'h02, 8'h01, 1'b0, KEEP_ALL);
      end else if (p == 2) begin
        build_frame(8'hFF, 8'hFF, rfp_pkg::CMD_READ_SERIAL, rfp_pkg::STATUS_OK,
                    rfp_pkg::TYPE_ID_OK, 1'b1, KEEP_ALL);
      end
      base = reply_bytes.size();
      while (reply_bytes.size() - base < BYTES_PER_PHASE) random_frame();
      if (p < NUM_PHASES - 1) begin
        build_frame(8'($urandom_range(6, 20)), 8'($urandom_range(0, 255)),
                    rfp_pkg::CMD_READ_SERIAL, rfp_pkg::STATUS_OK, rfp_pkg::TYPE_ID_OK,
                    1'b1, $urandom_range(1, 5));
      end
      wait_idle();
    end
    if (failures == 0 && reply_results.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
